// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSBG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSBG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ssbg_pkg.sv
// ----------------------------------------------------------------------------
// ssbg_pkg
// Shared widths, codes and types of the scatter/blend/gather unit.
// ----------------------------------------------------------------------------
package ssbg_pkg;

    // Memory geometry
    localparam int PARAM_WORDS = 65536;
    localparam int ADDR_W      = $clog2(PARAM_WORDS);

    // Field widths
    localparam int ROW_W    = 16;
    localparam int COL_W    = 16;
    localparam int SUB_W    = 8;
    localparam int STRIDE_W = 17;
    localparam int SCNT_W   = 9;
    localparam int GAIN_W   = 18;
    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 16;

    // Address arithmetic widths
    localparam int P1_W   = ROW_W + STRIDE_W;
    localparam int S1_W   = P1_W + 1;
    localparam int P2_W   = S1_W + SCNT_W;
    localparam int FULL_W = P2_W + 1;

    // Blend arithmetic widths
    localparam int PROD_W = GAIN_W + WORD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - FRAC_W;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SUB_COUNT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BETA_GAIN  = CFG_IDX_W'(3);

    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = STRIDE_W'(1);
    localparam logic [SCNT_W-1:0]   SUB_COUNT_RST  = SCNT_W'(1);
    localparam logic [GAIN_W-1:0]   GAIN_ONE       = GAIN_W'(65536);

    // Command and status codes
    localparam logic CMD_COMMIT   = 1'b0;
    localparam logic CMD_EXTRACT  = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic [STRIDE_W-1:0] row_stride;
        logic [SCNT_W-1:0]   sub_count;
        logic [GAIN_W-1:0]   alpha_gain;
        logic [GAIN_W-1:0]   beta_gain;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0] dest_row;
        logic [COL_W-1:0] dest_col;
        logic [SUB_W-1:0] sub_index;
    } t_loc;

    typedef struct packed {
        logic              valid;
        logic              bad;
        logic [ADDR_W-1:0] addr;
    } t_addr_res;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } t_blend_res;

endpackage

// File: src/ssbg_if.sv
// ----------------------------------------------------------------------------
// ssbg channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ssbg_in_if import ssbg_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [ROW_W-1:0]         dest_row;
    logic [COL_W-1:0]         dest_col;
    logic [SUB_W-1:0]         sub_index;
    logic signed [WORD_W-1:0] src_value;
    logic                     slice_last;

    modport source (output valid, cmd, dest_row, dest_col, sub_index, src_value,
                    slice_last, input ready);
    modport sink   (input valid, cmd, dest_row, dest_col, sub_index, src_value,
                    slice_last, output ready);
endinterface

interface ssbg_out_if import ssbg_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] word_value;
    logic                     status;
    logic                     slice_done;

    modport source (output valid, word_value, status, slice_done, input ready);
    modport sink   (input valid, word_value, status, slice_done, output ready);
endinterface

interface ssbg_cfg_if import ssbg_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: src/slice_scatter_blend_gather_unit.sv
// ----------------------------------------------------------------------------
// slice_scatter_blend_gather_unit
// Indexed scatter with blended update, and gather, on a parameter memory.
// ----------------------------------------------------------------------------
// After reset the unit zeroes its 65536-word parameter memory one word per
// cycle, so the item channel stays not-ready until the clear is done;
// configuration writes are taken throughout. The unit then holds one item at
// a time. Every item passes the three-stage address multiply chain; an
// in-range item then passes the registered memory read, and a commit also
// the two-stage blend multiplier that feeds the write-back. The result sits in
// an output register, so the next item is accepted while a result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slice_scatter_blend_gather_unit import ssbg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssbg_in_if.sink    i_in,
    ssbg_out_if.source o_out,
    ssbg_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_BLEND,
        ST_WAIT,
        ST_DONE
    } t_state;

    t_state             r_state;
    t_cfg               r_cfg;
    logic               r_go;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_bad;
    logic [WORD_W-1:0]  r_word;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_status;
    logic               r_out_done;

    logic               r_cmd;
    t_loc               r_loc;
    logic [WORD_W-1:0]  r_src;
    logic               r_last;

    logic               w_in_acc;
    logic               w_cfg_acc;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_blend_go;
    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [WORD_W-1:0]  w_wr_data;
    logic               w_rd_en;
    logic [WORD_W-1:0]  w_rd_data;
    t_addr_res          w_addr;
    t_blend_res         w_blend;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_out_load  = (r_state == ST_DONE) && w_out_free;

    assign o_out.valid      = r_out_valid;
    assign o_out.word_value = r_out_word;
    assign o_out.status     = r_out_status;
    assign o_out.slice_done = r_out_done;

    assign w_rd_en    = (r_state == ST_READ);
    assign w_blend_go = (r_state == ST_BLEND) && (r_cmd == CMD_COMMIT);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_addr;
        w_wr_data = w_blend.word;
        if (r_state == ST_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else if (r_state == ST_WAIT && w_blend.valid) begin
            w_wr_en = 1'b1;
        end
    end

    ssbg_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_loc   (r_loc),
        .i_cfg   (r_cfg),
        .o_res   (w_addr)
    );

    ssbg_ram #(
        .DEPTH (PARAM_WORDS),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    ssbg_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_blend_go),
        .i_old   (w_rd_data),
        .i_src   (r_src),
        .i_cfg   (r_cfg),
        .o_res   (w_blend)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_stride <= ROW_STRIDE_RST;
            r_cfg.sub_count  <= SUB_COUNT_RST;
            r_cfg.alpha_gain <= GAIN_ONE;
            r_cfg.beta_gain  <= GAIN_ONE;
        end else if (w_cfg_acc) begin
            unique case (i_cfg.addr)
                REG_ROW_STRIDE: r_cfg.row_stride <= i_cfg.data[STRIDE_W-1:0];
                REG_SUB_COUNT:  r_cfg.sub_count  <= i_cfg.data[SCNT_W-1:0];
                REG_ALPHA_GAIN: r_cfg.alpha_gain <= i_cfg.data[GAIN_W-1:0];
                REG_BETA_GAIN:  r_cfg.beta_gain  <= i_cfg.data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Item payload, held for the whole transaction
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd          <= i_in.cmd;
            r_loc.dest_row <= i_in.dest_row;
            r_loc.dest_col <= i_in.dest_col;
            r_loc.sub_index <= i_in.sub_index;
            r_src          <= i_in.src_value;
            r_last         <= i_in.slice_last;
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_go <= w_in_acc;
            if (r_out_valid && o_out.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr_addr == ADDR_W'(PARAM_WORDS - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    if (w_addr.valid) begin
                        r_addr <= w_addr.addr;
                        r_bad  <= w_addr.bad;
                        if (w_addr.bad) begin
                            r_word  <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_BLEND;
                end
                ST_BLEND: begin
                    if (r_cmd == CMD_EXTRACT) begin
                        r_word  <= w_rd_data;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (w_blend.valid) begin
                        r_word  <= w_blend.word;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_word   <= r_word;
                        r_out_status <= r_bad ? STATUS_RANGE : STATUS_OK;
                        r_out_done   <= r_last;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `SSBG_ASSERT_NOW(a_range_zero, i_clk, i_rst_n, o_out.valid && o_out.status == STATUS_RANGE, o_out.word_value == '0, "out-of-range result carries a nonzero word")
    `SSBG_ASSERT_NOW(a_port_excl, i_clk, i_rst_n, w_rd_en, !w_wr_en, "memory read and write in the same cycle")
    `SSBG_ASSERT_NOW(a_blend_wait, i_clk, i_rst_n, w_blend.valid, r_state == ST_WAIT, "blend result outside the write-back state")
    `SSBG_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, w_in_acc, !i_in.ready, "second item accepted while one is in flight")

endmodule

// File: src/ssbg_ram.sv
// ----------------------------------------------------------------------------
// ssbg_ram
// Simple dual-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module ssbg_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

// File: src/ssbg_addr.sv
// ----------------------------------------------------------------------------
// ssbg_addr
// Three-stage word address computation with bounds check.
// ----------------------------------------------------------------------------
module ssbg_addr import ssbg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_loc      i_loc,
    input  t_cfg      i_cfg,
    output t_addr_res o_res
);

    localparam logic [FULL_W-1:0] WORDS_EXT = FULL_W'(PARAM_WORDS);

    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic [P1_W-1:0]   r_p1;
    logic [P2_W-1:0]   r_p2;
    logic              r_fld_bad;
    logic              r_bad;
    logic [ADDR_W-1:0] r_addr;
    logic [S1_W-1:0]   w_s1;
    logic [FULL_W-1:0] w_full;

    // Loc fields are held by the caller for the whole transaction
    assign w_s1   = S1_W'(r_p1) + S1_W'(i_loc.dest_col);
    assign w_full = FULL_W'(r_p2) + FULL_W'(i_loc.sub_index);

    assign o_res = '{valid: r_v3, bad: r_bad, addr: r_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1      <= P1_W'(i_loc.dest_row) * P1_W'(i_cfg.row_stride);
        r_fld_bad <= (STRIDE_W'(i_loc.dest_col) >= i_cfg.row_stride)
                  || (SCNT_W'(i_loc.sub_index) >= i_cfg.sub_count);
        r_p2      <= P2_W'(w_s1) * P2_W'(i_cfg.sub_count);
        r_bad     <= r_fld_bad || (w_full >= WORDS_EXT);
        r_addr    <= w_full[ADDR_W-1:0];
    end

endmodule

// File: src/ssbg_blend.sv
// ----------------------------------------------------------------------------
// ssbg_blend
// alpha*old + beta*src in Q16.16 with round-half-up and saturation.
// ----------------------------------------------------------------------------
module ssbg_blend import ssbg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_old,
    input  logic [WORD_W-1:0] i_src,
    input  t_cfg              i_cfg,
    output t_blend_res        o_res
);

    localparam logic [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
    localparam logic [WORD_W-1:0] WORD_MAX   = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN   = {1'b1, {(WORD_W-1){1'b0}}};

    logic                      r_v1;
    logic                      r_v2;
    logic [WORD_W-1:0]         r_word;
    logic signed [PROD_W-1:0]  r_pa;
    logic signed [PROD_W-1:0]  r_pb;
    logic signed [SUM_W-1:0]   w_sum;
    logic [Q_W-1:0]            w_q;
    logic [Q_W-WORD_W:0]       w_hi;
    logic [WORD_W-1:0]         w_sat;

    assign w_sum = SUM_W'(r_pa) + SUM_W'(r_pb) + $signed(ROUND_HALF);
    // Arithmetic shift right by the fraction width
    assign w_q   = w_sum[SUM_W-1:FRAC_W];
    assign w_hi  = w_q[Q_W-1:WORD_W-1];

    assign o_res = '{valid: r_v2, word: r_word};

    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            w_sat = w_q[WORD_W-1:0];
        end else if (w_q[Q_W-1]) begin
            w_sat = WORD_MIN;
        end else begin
            w_sat = WORD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa   <= $signed(i_cfg.alpha_gain) * $signed(i_old);
        r_pb   <= $signed(i_cfg.beta_gain) * $signed(i_src);
        r_word <= w_sat;
    end

endmodule

// File: test/ssbg_checker.sv
// ----------------------------------------------------------------------------
// ssbg_checker
// Watches the item, result and configuration channels of the scatter/blend/
// gather unit. Keeps its own copy of the registers and of the parameter
// memory, works out the result of every accepted item and compares it, field
// by field, with the results that the unit hands out in order.
// ----------------------------------------------------------------------------
module ssbg_checker import ssbg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ssbg_in_if   i_in,
    ssbg_out_if  i_out,
    ssbg_cfg_if  i_cfg,
    output int   o_err_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_value;
        logic                     status;
        logic                     slice_done;
    } t_result;

    t_result                  result_fifo[$];
    logic [WORD_W-1:0]        param_shadow[int unsigned];
    logic [STRIDE_W-1:0]      stride_r;
    logic [SCNT_W-1:0]        scnt_r;
    logic signed [GAIN_W-1:0] alpha_r;
    logic signed [GAIN_W-1:0] beta_r;
    int                       err_total;

    // alpha*old + beta*src, rounded half up to Q16.16, then saturated
    function automatic logic [WORD_W-1:0] blend_word(input logic [WORD_W-1:0] old_w,
                                                     input logic [WORD_W-1:0] src_w);
        longint acc;
        longint q;
        acc = longint'(alpha_r) * longint'($signed(old_w))
            + longint'(beta_r) * longint'($signed(src_w));
        q = (acc + 64'sd32768) >>> FRAC_W;
        if (q > WORD_MAX) q = WORD_MAX;
        if (q < WORD_MIN) q = WORD_MIN;
        return q[WORD_W-1:0];
    endfunction

    // Also applies the commit to the shadow memory
    function automatic t_result predict_word(input logic cmd,
                                             input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] col,
                                             input logic [SUB_W-1:0] sub,
                                             input logic [WORD_W-1:0] src,
                                             input logic last);
        longint unsigned addr;
        logic            bad;
        int unsigned     key;
        logic [WORD_W-1:0] old_w;
        t_result         r;
        addr = (64'(row) * 64'(stride_r) + 64'(col)) * 64'(scnt_r) + 64'(sub);
        bad  = (col >= stride_r) || (sub >= scnt_r) || (addr >= 64'(PARAM_WORDS));
        r.word_value = '0;
        r.status     = bad ? STATUS_RANGE : STATUS_OK;
        r.slice_done = last;
        if (!bad) begin
            key   = int'(addr);
            old_w = param_shadow.exists(key) ? param_shadow[key] : '0;
            if (cmd == CMD_COMMIT) begin
                r.word_value = blend_word(old_w, src);
                param_shadow[key] = r.word_value;
            end else begin
                r.word_value = old_w;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            result_fifo.delete();
            param_shadow.delete();
            stride_r  = ROW_STRIDE_RST;
            scnt_r    = SUB_COUNT_RST;
            alpha_r   = GAIN_ONE;
            beta_r    = GAIN_ONE;
            err_total = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.addr)
                    REG_ROW_STRIDE: stride_r = i_cfg.data[STRIDE_W-1:0];
                    REG_SUB_COUNT:  scnt_r   = i_cfg.data[SCNT_W-1:0];
                    REG_ALPHA_GAIN: alpha_r  = i_cfg.data;
                    REG_BETA_GAIN:  beta_r   = i_cfg.data;
                    default: ;
                endcase
            end
            // compare the result before queueing this cycle's transaction
            if (i_out.valid && i_out.ready) begin
                if (result_fifo.size() == 0) begin
                    $error("unexpected result: word_value %0d status %0b slice_done %0b",
                           i_out.word_value, i_out.status, i_out.slice_done);
                    err_total++;
                end else begin
                    want = result_fifo.pop_front();
                    if (i_out.word_value !== want.word_value) begin
                        $error("word_value: expected %0d, got %0d",
                               want.word_value, i_out.word_value);
                        err_total++;
                    end
                    if (i_out.status !== want.status) begin
                        $error("status: expected %0b, got %0b", want.status, i_out.status);
                        err_total++;
                    end
                    if (i_out.slice_done !== want.slice_done) begin
                        $error("slice_done: expected %0b, got %0b",
                               want.slice_done, i_out.slice_done);
                        err_total++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                result_fifo.push_back(predict_word(i_in.cmd, i_in.dest_row, i_in.dest_col,
                                                   i_in.sub_index, i_in.src_value,
                                                   i_in.slice_last));
            end
        end
        o_err_count <= err_total;
        o_pending   <= result_fifo.size();
    end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the scatter/blend/gather unit: a directed pass over saturation,
// rounding, range limits and degenerate geometry, then phases of random items
// under changing register settings, with random gaps on both channels and two
// long receiver stalls. The checker beside the unit does the comparison.
// ----------------------------------------------------------------------------
module tb import ssbg_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_GAP        = 19;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_A      = 200;
    localparam int HOLD_AT_B      = 500;
    localparam int DRAIN_CYCLES   = 20;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 75;
    localparam int GAIN_SPAN      = 1 << GAIN_W;

    localparam logic [CFG_IDX_W-1:0]  REG_UNMAPPED = CFG_IDX_W'(9);
    localparam logic [CFG_DATA_W-1:0] GAIN_MIN     = CFG_DATA_W'(18'h20000);
    localparam logic [CFG_DATA_W-1:0] GAIN_MAX     = CFG_DATA_W'(18'h1FFFF);

    logic        clk;
    logic        rst_n;
    int          err_count;
    int          pending;
    int          idle_cycles;
    int          sent_count;
    int unsigned cur_stride;
    int unsigned cur_scnt;

    ssbg_in_if  in_ch();
    ssbg_out_if out_ch();
    ssbg_cfg_if cfg_ch();

    slice_scatter_blend_gather_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ssbg_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg       (cfg_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // one stretch in four runs without gaps
    function automatic int draw_gap(input int seq, input int period);
        if ((seq / period) % 4 == 1) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // leaves valid high; the caller drops it at the end of a burst
    task automatic send_item(input logic cmd, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [SUB_W-1:0] sub,
                             input logic [WORD_W-1:0] src, input logic last);
        int gap;
        gap = draw_gap(sent_count, 50);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.dest_row   <= row;
        in_ch.dest_col   <= col;
        in_ch.sub_index  <= sub;
        in_ch.src_value  <= src;
        in_ch.slice_last <= last;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        sent_count++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            REG_ROW_STRIDE: cur_stride = 32'(value[STRIDE_W-1:0]);
            REG_SUB_COUNT:  cur_scnt   = 32'(value[SCNT_W-1:0]);
            default: ;
        endcase
    endtask

    // drop valid, then hold until every result has come back
    task automatic settle();
        in_ch.valid  <= 1'b0;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return GAIN_MIN;
            1: return GAIN_MAX;
            2: return '0;
            3: return GAIN_ONE;
            default: return CFG_DATA_W'($urandom_range(0, GAIN_SPAN - 1));
        endcase
    endfunction

    task automatic random_item();
        int unsigned      kind;
        int unsigned      cmax;
        int unsigned      row_max;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [SUB_W-1:0] sub;
        logic [WORD_W-1:0] src;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            // small hot set so commits and extracts keep hitting the same words
            sub = SUB_W'($urandom_range(0, min_u(cur_scnt - 1, 3)));
            col = COL_W'($urandom_range(0, min_u(cur_stride - 1, 3)));
            row = ROW_W'($urandom_range(0, 3));
            if ((row * cur_stride + col) * cur_scnt + sub >= PARAM_WORDS) row = '0;
        end else if (kind <= 8) begin
            sub     = SUB_W'($urandom_range(0, cur_scnt - 1));
            cmax    = (PARAM_WORDS - 1 - sub) / cur_scnt;
            col     = COL_W'($urandom_range(0, min_u(cur_stride - 1, cmax)));
            row_max = (cmax - col) / cur_stride;
            // any row in range, or for kind 8 the top of the address range or just past it
            row = (kind == 8) ? ROW_W'(row_max + $urandom_range(0, 1))
                              : ROW_W'($urandom_range(0, row_max));
        end else begin
            row = ROW_W'($urandom);
            col = COL_W'($urandom);
            sub = SUB_W'($urandom);
        end
        case ($urandom_range(0, 5))
            0: src = 32'h7FFF_FFFF;
            1: src = 32'h8000_0000;
            2, 3: src = $urandom;
            default: src = 32'($urandom_range(0, 262144)) - 32'd131072;
        endcase
        send_item(1'($urandom_range(0, 1)), row, col, sub, src, 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] stride_v;
        logic [CFG_DATA_W-1:0] scnt_v;
        logic [CFG_DATA_W-1:0] alpha_v;
        logic [CFG_DATA_W-1:0] beta_v;
        sent_count       = 0;
        cur_stride       = 1;
        cur_scnt         = 1;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.cmd        <= CMD_COMMIT;
        in_ch.dest_row   <= '0;
        in_ch.dest_col   <= '0;
        in_ch.sub_index  <= '0;
        in_ch.src_value  <= '0;
        in_ch.slice_last <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.addr      <= REG_ROW_STRIDE;
        cfg_ch.data      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: one column, one sub-element, unit gains
        send_item(CMD_EXTRACT, 16'd0,     16'd0,     8'd0,   32'h0000_0000, 1'b0);
        send_item(CMD_EXTRACT, 16'd65535, 16'd0,     8'd0,   32'h0000_0000, 1'b1);
        send_item(CMD_COMMIT,  16'd0,     16'd0,     8'd0,   32'h7FFF_FFFF, 1'b0);
        send_item(CMD_COMMIT,  16'd0,     16'd0,     8'd0,   32'h0000_0001, 1'b0);
        send_item(CMD_COMMIT,  16'd65535, 16'd0,     8'd0,   32'h8000_0000, 1'b0);
        send_item(CMD_COMMIT,  16'd65535, 16'd0,     8'd0,   32'hFFFF_FFFF, 1'b1);
        send_item(CMD_EXTRACT, 16'd65535, 16'd0,     8'd0,   32'hFFFF_FFFF, 1'b0);
        send_item(CMD_COMMIT,  16'd0,     16'd65535, 8'd0,   32'h0000_0005, 1'b0);
        send_item(CMD_EXTRACT, 16'd0,     16'd0,     8'd255, 32'h0000_0000, 1'b1);
        send_item(CMD_COMMIT,  16'd2,     16'd0,     8'd0,   32'h1234_5678, 1'b1);
        send_item(CMD_EXTRACT, 16'd2,     16'd0,     8'd0,   32'h0000_0000, 1'b0);
        settle();

        // widest geometry with extreme gains: address limit and half rounding
        cfg_write(REG_ROW_STRIDE, CFG_DATA_W'(65536));
        cfg_write(REG_SUB_COUNT,  CFG_DATA_W'(256));
        cfg_write(REG_ALPHA_GAIN, GAIN_MIN);
        cfg_write(REG_BETA_GAIN,  GAIN_MAX);
        cfg_ch.valid <= 1'b0;
        send_item(CMD_COMMIT,  16'd0,     16'd0,     8'd0,   32'h7FFF_FFFF, 1'b0);
        send_item(CMD_COMMIT,  16'd0,     16'd255,   8'd255, 32'h8000_0000, 1'b1);
        send_item(CMD_COMMIT,  16'd0,     16'd256,   8'd0,   32'h0000_0001, 1'b0);
        send_item(CMD_EXTRACT, 16'd65535, 16'd65535, 8'd255, 32'h0000_0000, 1'b1);
        send_item(CMD_COMMIT,  16'd0,     16'd1,     8'd0,   32'h0000_8000, 1'b0);
        send_item(CMD_COMMIT,  16'd0,     16'd1,     8'd1,   32'hFFFF_8000, 1'b0);
        send_item(CMD_EXTRACT, 16'd0,     16'd1,     8'd0,   32'h0000_0000, 1'b1);
        settle();

        // stride field masked to zero: nothing is in range
        cfg_write(REG_ROW_STRIDE, CFG_DATA_W'(18'h20000));
        cfg_ch.valid <= 1'b0;
        send_item(CMD_COMMIT,  16'd0, 16'd0, 8'd0, 32'h0000_0100, 1'b0);
        send_item(CMD_EXTRACT, 16'd0, 16'd0, 8'd0, 32'h0000_0000, 1'b1);
        settle();

        // sub-element count masked to zero
        cfg_write(REG_ROW_STRIDE, CFG_DATA_W'(1));
        cfg_write(REG_SUB_COUNT,  CFG_DATA_W'(18'h00200));
        cfg_ch.valid <= 1'b0;
        send_item(CMD_COMMIT,  16'd0, 16'd0, 8'd0, 32'h0000_0100, 1'b1);
        send_item(CMD_EXTRACT, 16'd2, 16'd0, 8'd0, 32'h0000_0000, 1'b0);
        settle();

        // a write to an unmapped index must leave everything as it was
        cfg_write(REG_SUB_COUNT, CFG_DATA_W'(1));
        cfg_write(REG_UNMAPPED,  CFG_DATA_W'(18'h3FFFF));
        cfg_ch.valid <= 1'b0;
        send_item(CMD_EXTRACT, 16'd2, 16'd0, 8'd0, 32'h0000_0000, 1'b0);
        send_item(CMD_COMMIT,  16'd2, 16'd0, 8'd0, 32'h0000_0000, 1'b1);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: stride_v = CFG_DATA_W'(1);
                1: stride_v = CFG_DATA_W'(65536);
                2: stride_v = CFG_DATA_W'($urandom_range(1, 8));
                3: stride_v = CFG_DATA_W'($urandom_range(1, 300));
                default: stride_v = CFG_DATA_W'($urandom_range(1, 65536));
            endcase
            case ($urandom_range(0, 3))
                0: scnt_v = CFG_DATA_W'(1);
                1: scnt_v = CFG_DATA_W'(256);
                2: scnt_v = CFG_DATA_W'($urandom_range(1, 8));
                default: scnt_v = CFG_DATA_W'($urandom_range(1, 256));
            endcase
            alpha_v = pick_gain();
            beta_v  = pick_gain();
            // pin the opposite corners in the first two phases
            if (ph == 0) begin
                stride_v = CFG_DATA_W'(65536);
                scnt_v   = CFG_DATA_W'(256);
                alpha_v  = GAIN_MAX;
                beta_v   = GAIN_MIN;
            end else if (ph == 1) begin
                stride_v = CFG_DATA_W'(1);
                scnt_v   = CFG_DATA_W'(1);
                alpha_v  = GAIN_MIN;
                beta_v   = GAIN_MAX;
            end
            cfg_write(REG_ROW_STRIDE, stride_v);
            cfg_write(REG_SUB_COUNT,  scnt_v);
            cfg_write(REG_ALPHA_GAIN, alpha_v);
            cfg_write(REG_BETA_GAIN,  beta_v);
            if ($urandom_range(0, 2) == 0)
                cfg_write(REG_UNMAPPED, CFG_DATA_W'($urandom_range(0, GAIN_SPAN - 1)));
            cfg_ch.valid <= 1'b0;
            for (int k = 0; k < PHASE_ITEMS; k++) random_item();
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("** slice_scatter_blend_gather_unit: PASSED **");
        end else begin
            $display("** slice_scatter_blend_gather_unit: FAILED **");
        end
        $finish;
    end

    // Result side: random back-pressure, plus two long stalls that back up the unit
    initial begin : result_drain
        int taken;
        int hold;
        taken = 0;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (taken == HOLD_AT_A || taken == HOLD_AT_B) hold = HOLD_CYCLES;
            else hold = draw_gap(taken, 35);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
            taken++;
        end
    end

    // Abort when no transaction moves on any channel for too long
    initial idle_cycles = 0;
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** slice_scatter_blend_gather_unit: FAILED **");
            $finish;
        end
    end

endmodule

// File: slice_scatter_blend_gather_unit.f
+incdir+src
src/ssbg_pkg.sv
src/ssbg_if.sv
src/ssbg_ram.sv
src/ssbg_addr.sv
src/ssbg_blend.sv
src/slice_scatter_blend_gather_unit.sv
test/ssbg_checker.sv
test/tb.sv
